// ===== sv/dcd_pkg.sv =====
// ----------------------------------------------------------------------------
// Day count to calendar date - shared definitions
// Table constants and defaults for the day count to date converter.
// ----------------------------------------------------------------------------
`default_nettype none

package dcd_pkg;

  localparam int unsigned DAY_COUNT_BITS_DEF = 20;
  localparam int unsigned EPOCH_W            = 12;
  localparam logic [11:0] EPOCH_RESET        = 12'd1980;

  // days in one four-year cycle
  localparam int unsigned DAYS_PER_CYCLE     = 1461;

  // start day of each cycle year within a four-year cycle, by epoch mod 4
  localparam logic [10:0] CYCLE_START [4][5] = '{
    '{11'd0, 11'd366, 11'd731, 11'd1096, 11'd1461},
    '{11'd0, 11'd365, 11'd730, 11'd1095, 11'd1461},
    '{11'd0, 11'd365, 11'd730, 11'd1096, 11'd1461},
    '{11'd0, 11'd365, 11'd731, 11'd1096, 11'd1461}
  };

  // cycle year that holds the leap day, by epoch mod 4
  localparam logic [1:0] LEAP_SLOT [4] = '{2'd0, 2'd3, 2'd2, 2'd1};

  localparam logic [8:0] CUM_COMMON [13] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
  };
  localparam logic [8:0] CUM_LEAP [13] = '{
    9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
    9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366
  };

endpackage

`default_nettype wire

// ===== sv/day_count_to_calendar_date_core.sv =====
// ----------------------------------------------------------------------------
// Day count to calendar date converter
// Turns a day count plus Q0.32 day fraction into year, month, day, hour,
// minute and Q6.16 seconds, relative to a programmable epoch year (Julian
// leap rule, every fourth year).
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis_*: one timestamp per transaction, day 1 is January 1
//   of the epoch year. Output stream m_axis_*: one date per transaction, in
//   the same order. The epoch year is written through cfg_wr_en_i /
//   cfg_wr_data_i while no transaction is in flight.
// Pipeline and throughput:
//   Four register stages: m_axis_tvalid is the valid bit of the fourth
//   stage. One transaction is taken every cycle while the output is not
//   stalled.
// Reset:
//   All stage valid bits clear and the epoch year returns to 1980.
// Stall:
//   While the output holds an untaken result, the whole pipeline holds and
//   s_axis_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module day_count_to_calendar_date_core #(
  parameter int unsigned DAY_COUNT_BITS = dcd_pkg::DAY_COUNT_BITS_DEF,
  localparam int unsigned S_TDATA_W = ((DAY_COUNT_BITS + 32 + 7) / 8) * 8,
  localparam int unsigned M_TDATA_W = 56
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_wr_en_i,
  input  wire logic [dcd_pkg::EPOCH_W-1:0]   cfg_wr_data_i,   // epoch_year
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  // day_count[DAY_COUNT_BITS], day_fraction[32], zero fill
  input  wire logic [S_TDATA_W-1:0]          s_axis_tdata,
  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // year[13], month[4], day_of_month[5], hour[5], minute[6],
  // second_scaled[22], zero fill
  output      logic [M_TDATA_W-1:0]          m_axis_tdata
);

  localparam int unsigned DCB         = DAY_COUNT_BITS;
  localparam int unsigned CW          = DCB - 10;
  localparam int unsigned RECIP_SHIFT = DCB + 10;
  localparam logic [DCB-1:0] RECIP_MULT =
    DCB'((64'd1 << RECIP_SHIFT) / 64'(dcd_pkg::DAYS_PER_CYCLE));
  localparam logic [11:0] CYC_DAYS = 12'(dcd_pkg::DAYS_PER_CYCLE);

  logic                    adv;
  logic [dcd_pkg::EPOCH_W-1:0] epoch_q;

  logic v1_q, v2_q, v3_q, v4_q;

  // stage 1
  logic [DCB-1:0]    days_d, days1_q;
  logic [2*DCB-1:0]  prod_d, prod1_q;
  logic [36:0]       hp_d, hp1_q;
  // stage 2
  logic [CW-1:0]     qest;
  logic [DCB-1:0]    rem_full;
  logic [11:0]       rem_lo;
  logic [CW-1:0]     cyc_d, cyc2_q;
  logic [10:0]       rem2_d, rem2_q;
  logic [37:0]       mp_d, mp2_q;
  logic [4:0]        hour2_q;
  // stage 3
  logic [1:0]        yi;
  logic [1:0]        ph;
  logic [31:0]       ysum;
  logic [8:0]        remy_d, rem3_q;
  logic              leap_d, leap3_q;
  logic [12:0]       year3_q;
  logic [37:0]       sp_d, sp3_q;
  logic [4:0]        hour3_q;
  logic [5:0]        min3_q;
  // stage 4
  logic [3:0]        mi;
  logic [8:0]        cum_sel;
  logic [8:0]        dom_d;
  logic [12:0]       year4_q;
  logic [3:0]        month4_q;
  logic [4:0]        dom4_q;
  logic [4:0]        hour4_q;
  logic [5:0]        min4_q;
  logic [21:0]       sec4_q;

  assign adv           = !v4_q || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q <= dcd_pkg::EPOCH_RESET;
    end else if (cfg_wr_en_i) begin
      epoch_q <= cfg_wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Stage 1: elapsed days, reciprocal product, hour product
  always_comb begin
    days_d = s_axis_tdata[DCB-1:0] - DCB'(1);
    prod_d = (2*DCB)'(days_d) * (2*DCB)'(RECIP_MULT);
    hp_d   = 37'(s_axis_tdata[DCB+31:DCB]) * 37'(24);
  end

  // Stage 2: cycle count with one correction step, minute product
  always_comb begin
    qest     = prod1_q[2*DCB-1:RECIP_SHIFT];
    rem_full = days1_q - DCB'(DCB'(qest) * DCB'(dcd_pkg::DAYS_PER_CYCLE));
    rem_lo   = rem_full[11:0];
    if (rem_lo >= CYC_DAYS) begin
      rem2_d = 11'(rem_lo - CYC_DAYS);
      cyc_d  = qest + CW'(1);
    end else begin
      rem2_d = rem_lo[10:0];
      cyc_d  = qest;
    end
    mp_d = 38'(hp1_q[31:0]) * 38'(60);
  end

  // Stage 3: year within the cycle, second product
  always_comb begin
    ph = epoch_q[1:0];
    yi = 2'd0;
    for (int k = 1; k < 4; k++) begin
      if (rem2_q >= dcd_pkg::CYCLE_START[ph][3'(k)]) begin
        yi = 2'(k);
      end
    end
    remy_d = 9'(rem2_q - dcd_pkg::CYCLE_START[ph][{1'b0, yi}]);
    leap_d = (dcd_pkg::LEAP_SLOT[ph] == yi);
    ysum   = 32'({cyc2_q, 2'b00}) + 32'(yi) + 32'(epoch_q);
    sp_d   = 38'(mp2_q[31:0]) * 38'(60);
  end

  // Stage 4: month search against the cumulative table
  always_comb begin
    mi = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (leap3_q ? (rem3_q >= dcd_pkg::CUM_LEAP[4'(k)])
                  : (rem3_q >= dcd_pkg::CUM_COMMON[4'(k)])) begin
        mi = 4'(k);
      end
    end
    cum_sel = leap3_q ? dcd_pkg::CUM_LEAP[mi] : dcd_pkg::CUM_COMMON[mi];
    dom_d   = rem3_q - cum_sel + 9'd1;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      days1_q  <= days_d;
      prod1_q  <= prod_d;
      hp1_q    <= hp_d;

      cyc2_q   <= cyc_d;
      rem2_q   <= rem2_d;
      mp2_q    <= mp_d;
      hour2_q  <= hp1_q[36:32];

      rem3_q   <= remy_d;
      leap3_q  <= leap_d;
      year3_q  <= ysum[12:0];
      sp3_q    <= sp_d;
      hour3_q  <= hour2_q;
      min3_q   <= mp2_q[37:32];

      year4_q  <= year3_q;
      month4_q <= mi + 4'd1;
      dom4_q   <= dom_d[4:0];
      hour4_q  <= hour3_q;
      min4_q   <= min3_q;
      sec4_q   <= sp3_q[37:16];
    end
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = {1'b0, sec4_q, min4_q, hour4_q, dom4_q, month4_q, year4_q};

  // Checks
  a_rem_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> rem2_q < CYC_DAYS[10:0])
    else $error("day remainder not reduced below one cycle");

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q |-> (month4_q >= 4'd1 && month4_q <= 4'd12))
    else $error("month out of range");

  a_dom_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q |-> (dom4_q >= 5'd1))
    else $error("day of month is zero");

  a_hour_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> hour2_q < 5'd24)
    else $error("hour out of range");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(year4_q) && $stable(sec4_q) && $stable(v3_q))
    else $error("pipeline moved during stall");

endmodule

`default_nettype wire
